// File: hdl/mttd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttd_pkg
// Shared sizes, byte codes, types and states for the Morse token decoder.
// ----------------------------------------------------------------------------
package mttd_pkg;

  // Sizes
  localparam int MAX_ENTRIES   = 64;
  localparam int MAX_CODE_LEN  = 12;
  localparam int MAX_TOKEN_LEN = 14;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ENTRY_AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int CLEN_W    = $clog2(MAX_CODE_LEN + 1);
  localparam int TLEN_W    = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CIDX_W    = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int TIDX_W    = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam int CMP_N     = (MAX_CODE_LEN < MAX_TOKEN_LEN) ? MAX_CODE_LEN : MAX_TOKEN_LEN;
  localparam int LEN_CMP_W = (CLEN_W > TLEN_W) ? CLEN_W : TLEN_W;
  localparam int Q_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Byte codes
  localparam logic [7:0] SLASH_BYTE   = 8'h2F;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] TAB_BYTE     = 8'h09;
  localparam logic [7:0] CR_BYTE      = 8'h0D;

  // Item kinds
  localparam logic KIND_TABLE   = 1'b0;
  localparam logic KIND_MESSAGE = 1'b1;

  // One table entry as stored in the table RAM
  typedef struct packed {
    logic [7:0]                   letter;
    logic [CLEN_W-1:0]            len;
    logic [MAX_CODE_LEN-1:0][7:0] code;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Table RAM write request from the front
  typedef struct packed {
    logic                we;
    logic [ENTRY_AW-1:0] addr;
    row_t                row;
  } tbl_wr_t;

  // Finished token waiting for lookup
  typedef struct packed {
    logic [MAX_TOKEN_LEN-1:0][7:0] chars;
    logic [TLEN_W-1:0]             len;
    logic                          ovf;
  } job_t;

  // Position inside a table line
  typedef enum logic [1:0] {
    LP_LETTER,
    LP_SKIP,
    LP_CODE
  } line_pos_t;

  // Lookup engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

endpackage

// File: hdl/mttd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mttd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/mttd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttd_front
// Accepts raw bytes: builds table entries and cuts message bytes into tokens.
// ----------------------------------------------------------------------------
module mttd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  logic                   kind,
  input  logic [7:0]             byte_in,
  input  logic                   last,
  input  logic                   lookup_pending,
  input  logic                   q_full,
  output logic                   push,
  output mttd_pkg::job_t         push_job,
  output mttd_pkg::tbl_wr_t      tbl_wr,
  output logic [mttd_pkg::COUNT_W-1:0] entry_count
);

  import mttd_pkg::*;

  // Table line state
  line_pos_t                    line_pos, line_pos_next;
  logic                         line_dropped, line_dropped_next;
  logic [COUNT_W-1:0]           count_next;
  logic [7:0]                   cur_letter, cur_letter_next;
  logic [CLEN_W-1:0]            cur_len, cur_len_next;
  logic [MAX_CODE_LEN-1:0][7:0] cur_code, cur_code_next;
  logic [COUNT_W-1:0]           count_m1;

  // Token state
  logic [MAX_TOKEN_LEN-1:0][7:0] tok_chars, tok_chars_next;
  logic [TLEN_W-1:0]             tok_len, tok_len_next;
  logic                          tok_ovf, tok_ovf_next;
  logic [MAX_TOKEN_LEN-1:0][7:0] upd_chars;
  logic [TLEN_W-1:0]             upd_len;
  logic                          upd_ovf;

  logic accept;
  logic blank;

  // Table bytes wait while any lookup is queued or running; message bytes wait on a full queue
  assign byte_stall = (kind == KIND_MESSAGE) ? q_full : lookup_pending;
  assign accept     = byte_valid && !byte_stall;
  assign blank      = (byte_in == SPACE_BYTE) || ((byte_in >= TAB_BYTE) && (byte_in <= CR_BYTE));
  assign count_m1   = entry_count - COUNT_W'(1);

  // Table line handling
  always_comb begin
    line_pos_next     = line_pos;
    line_dropped_next = line_dropped;
    count_next        = entry_count;
    cur_letter_next   = cur_letter;
    cur_len_next      = cur_len;
    cur_code_next     = cur_code;
    tbl_wr.we         = 1'b0;
    tbl_wr.addr       = count_m1[ENTRY_AW-1:0];
    tbl_wr.row.letter = cur_letter;
    tbl_wr.row.len    = cur_len;
    tbl_wr.row.code   = cur_code;
    if (accept && (kind == KIND_TABLE)) begin
      if (byte_in == NEWLINE_BYTE) begin
        line_pos_next     = LP_LETTER;
        line_dropped_next = 1'b0;
      end else begin
        unique case (line_pos)
          LP_LETTER: begin
            if (entry_count < COUNT_W'(MAX_ENTRIES)) begin
              tbl_wr.we         = 1'b1;
              tbl_wr.addr       = entry_count[ENTRY_AW-1:0];
              tbl_wr.row.letter = byte_in;
              tbl_wr.row.len    = '0;
              cur_letter_next   = byte_in;
              cur_len_next      = '0;
              count_next        = entry_count + COUNT_W'(1);
              line_dropped_next = 1'b0;
            end else begin
              line_dropped_next = 1'b1;
            end
            line_pos_next = LP_SKIP;
          end
          LP_SKIP: begin
            line_pos_next = LP_CODE;
          end
          LP_CODE: begin
            // Append to the newest entry, ignoring bytes past the code limit
            if (!line_dropped && (entry_count != '0) &&
                (cur_len < CLEN_W'(MAX_CODE_LEN))) begin
              cur_code_next[cur_len[CIDX_W-1:0]] = byte_in;
              cur_len_next      = cur_len + CLEN_W'(1);
              tbl_wr.we         = 1'b1;
              tbl_wr.row.len    = cur_len_next;
              tbl_wr.row.code   = cur_code_next;
            end
          end
          default: begin
            line_pos_next = LP_LETTER;
          end
        endcase
        if (last) begin
          line_pos_next     = LP_LETTER;
          line_dropped_next = 1'b0;
        end
      end
    end
  end

  // Token building and hand-off
  always_comb begin
    upd_chars      = tok_chars;
    upd_len        = tok_len;
    upd_ovf        = tok_ovf;
    tok_chars_next = tok_chars;
    tok_len_next   = tok_len;
    tok_ovf_next   = tok_ovf;
    push           = 1'b0;
    push_job.chars = tok_chars;
    push_job.len   = tok_len;
    push_job.ovf   = tok_ovf;
    if (accept && (kind == KIND_MESSAGE)) begin
      if (blank) begin
        if ((tok_len != '0) || tok_ovf) begin
          push         = 1'b1;
          tok_len_next = '0;
          tok_ovf_next = 1'b0;
        end
      end else begin
        if (tok_len < TLEN_W'(MAX_TOKEN_LEN)) begin
          upd_chars[tok_len[TIDX_W-1:0]] = byte_in;
          upd_len = tok_len + TLEN_W'(1);
        end else begin
          upd_ovf = 1'b1;
        end
        tok_chars_next = upd_chars;
        if (last) begin
          push           = 1'b1;
          push_job.chars = upd_chars;
          push_job.len   = upd_len;
          push_job.ovf   = upd_ovf;
          tok_len_next   = '0;
          tok_ovf_next   = 1'b0;
        end else begin
          tok_len_next = upd_len;
          tok_ovf_next = upd_ovf;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos     <= LP_LETTER;
      line_dropped <= 1'b0;
      entry_count  <= '0;
      tok_len      <= '0;
      tok_ovf      <= 1'b0;
    end else begin
      line_pos     <= line_pos_next;
      line_dropped <= line_dropped_next;
      entry_count  <= count_next;
      tok_len      <= tok_len_next;
      tok_ovf      <= tok_ovf_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_letter <= cur_letter_next;
    cur_len    <= cur_len_next;
    cur_code   <= cur_code_next;
    tok_chars  <= tok_chars_next;
  end

endmodule

// File: hdl/mttd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttd_queue
// Small FIFO of finished tokens between the front and the lookup engine.
// ----------------------------------------------------------------------------
module mttd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mttd_pkg::job_t push_job,
  input  logic           pop,
  output mttd_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  import mttd_pkg::*;

  job_t               slots [QUEUE_DEPTH];
  logic [Q_AW-1:0]    wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == Q_CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// File: hdl/mttd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mttd_back
// Lookup engine: walks the table one entry per cycle, emits letter or space.
// ----------------------------------------------------------------------------
module mttd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  mttd_pkg::job_t                head,
  input  logic                          q_empty,
  output logic                          pop,
  input  logic [mttd_pkg::COUNT_W-1:0]  entry_count,
  output logic [mttd_pkg::ENTRY_AW-1:0] rd_addr,
  input  logic [mttd_pkg::ROW_W-1:0]    rd_data,
  output logic                          busy,
  output logic                          char_valid,
  input  logic                          char_stall,
  output logic [7:0]                    decoded_char
);

  import mttd_pkg::*;

  back_state_t         state, state_next;
  job_t                job;
  logic [ENTRY_AW-1:0] scan_idx;
  logic [7:0]          res_char;
  row_t                row;
  logic                hit, slash_hit, more;
  logic                scan_step, res_load, out_load;

  // Exact code compare of one entry against the token
  function automatic logic row_match(row_t r, job_t j);
    logic eq;
    eq = !j.ovf && (LEN_CMP_W'(r.len) == LEN_CMP_W'(j.len));
    for (int i = 0; i < CMP_N; i++) begin
      if ((CLEN_W'(i) < r.len) && (r.code[i] != j.chars[i])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

  assign row       = row_t'(rd_data);
  assign hit       = (COUNT_W'(scan_idx) < entry_count) && row_match(row, job);
  assign slash_hit = !hit && (scan_idx == '0) && (job.chars[0] == SLASH_BYTE);
  assign more      = !job.ovf && ((COUNT_W'(scan_idx) + COUNT_W'(1)) < entry_count);
  assign busy      = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (hit || slash_hit) begin
          state_next = ST_EMIT;
        end else if (more) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!char_valid || !char_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    pop       = 1'b0;
    rd_addr   = '0;
    scan_step = 1'b0;
    res_load  = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop = !q_empty;
      end
      ST_SCAN: begin
        res_load  = hit || slash_hit;
        scan_step = !hit && !slash_hit && more;
        rd_addr   = scan_idx + ENTRY_AW'(1);
      end
      ST_EMIT: begin
        out_load = !char_valid || !char_stall;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  // Working registers and output register
  always_ff @(posedge clk) begin
    if (pop) begin
      job      <= head;
      scan_idx <= '0;
    end else if (scan_step) begin
      scan_idx <= scan_idx + ENTRY_AW'(1);
    end
    if (res_load) begin
      res_char <= hit ? row.letter : SPACE_BYTE;
    end
    if (out_load) begin
      decoded_char <= res_char;
    end
  end

endmodule

// File: hdl/morse_table_token_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_table_token_decoder_unit
// Table-driven Morse decoder: builds a code table and decodes message tokens.
// ----------------------------------------------------------------------------
// Input channel (byte_valid / byte_stall) carries one raw byte per item with
// kind (0 = table byte, 1 = message byte) and last. Output channel
// (char_valid / char_stall) carries one decoded character per item.
// Table bytes are written into the table RAM as they are taken; they
// are held off while any token lookup is queued or running.
// Message bytes are taken every cycle while the token queue has room. Each
// finished token goes to a two-deep queue; the lookup engine pops it,
// then reads one table entry per cycle (up to 64 entries) and hands the
// result to the output register, one token at a time; tokens with no
// match give no item.
// The single-port-read table RAM sets the walk rate of one entry per cycle.
// Reset clears all counters and the queue; table contents need no clearing,
// entries past the entry count are never matched.
// A stalled output holds its character; the engine waits, and the front keeps
// taking message bytes until the queue is full.
// ----------------------------------------------------------------------------
module morse_table_token_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic       kind,
  input  logic [7:0] byte_in,
  input  logic       last,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [7:0] decoded_char
);

  import mttd_pkg::*;

  job_t                push_job, head;
  tbl_wr_t             tbl_wr;
  logic                push, pop, q_empty, q_full, back_busy;
  logic [COUNT_W-1:0]  entry_count;
  logic [ENTRY_AW-1:0] rd_addr;
  logic [ROW_W-1:0]    rd_data;

  mttd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .kind           (kind),
    .byte_in        (byte_in),
    .last           (last),
    .lookup_pending (back_busy || !q_empty),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job),
    .tbl_wr         (tbl_wr),
    .entry_count    (entry_count)
  );

  mttd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  mttd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_wr.we),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.row),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mttd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .entry_count  (entry_count),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (back_busy),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .decoded_char (decoded_char)
  );

endmodule

// File: tb/morse_table_token_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_table_token_decoder_unit_test
// Self-checking bench for the Morse table and token decoder.
// ----------------------------------------------------------------------------
// Table and message bytes are fed through the byte channel. Every accepted
// byte also drives a cycle-free model of the code table and the token buffer,
// which queues the characters the block owes. Each character taken from the
// output is checked in order against that queue. A directed opener covers the
// corner cases. Random phases follow, mostly well-formed table lines and
// tokens, with sender gaps and receiver stalls at several rates, one long
// receiver hold-off and pauses until all owed characters have come out.
// ----------------------------------------------------------------------------
module morse_table_token_decoder_unit_test;
  import mttd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 220;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 100;
  localparam int FULL_LINES  = MAX_ENTRIES + 8;

  localparam logic [7:0] DOT_BYTE  = 8'h2E;
  localparam logic [7:0] DASH_BYTE = 8'h2D;
  localparam logic [7:0] VT_BYTE   = 8'h0B;
  localparam logic [7:0] FF_BYTE   = 8'h0C;

  // One byte waiting to be sent; drain holds it back until nothing is owed
  typedef struct packed {
    logic       drain;
    logic       kind;
    logic [7:0] data;
    logic       fin;
  } byte_item_t;

  logic       clk;
  logic       rst          = 1'b1;
  logic       byte_valid   = 1'b0;
  logic       byte_stall;
  logic       kind         = 1'b0;
  logic [7:0] byte_in      = 8'h00;
  logic       last         = 1'b0;
  logic       char_valid;
  logic       char_stall   = 1'b0;
  logic [7:0] decoded_char;

  morse_table_token_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .kind         (kind),
    .byte_in      (byte_in),
    .last         (last),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .decoded_char (decoded_char)
  );

  // Model state: code table and pending token
  logic [7:0] tbl_letter [MAX_ENTRIES];
  logic [7:0] tbl_code   [MAX_ENTRIES][MAX_CODE_LEN];
  int         tbl_len    [MAX_ENTRIES];
  int         tbl_count;
  line_pos_t  line_pos;
  bit         line_drop;
  logic [7:0] tok [MAX_TOKEN_LEN];
  int         tok_len;
  bit         tok_ovf;

  byte_item_t pending [$];
  logic [7:0] chars_due [$];
  byte_item_t nxt;
  logic [7:0] ch_new;
  logic [7:0] ch_want;
  int         mismatches  = 0;
  int         cycle_count = 0;
  int         queued      = 0;
  bit         drain_next  = 1'b0;

  // Handshake pressure knobs
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_asked   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // Stimulus bookkeeping: codes of the first table lines, for hitting tokens
  logic [7:0] pool_code [MAX_ENTRIES][MAX_CODE_LEN];
  int         pool_len  [MAX_ENTRIES];
  int         pool_n     = 0;
  int         lines_made = 0;
  logic [7:0] tok_buf [24];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_blank(input logic [7:0] b);
    return b == SPACE_BYTE || (b >= TAB_BYTE && b <= CR_BYTE);
  endfunction

  function automatic bit token_hits(input int e);
    if (tok_ovf || tbl_len[e] != tok_len) return 1'b0;
    for (int i = 0; i < tbl_len[e]; i++) begin
      if (tbl_code[e][i] != tok[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Look up the pending token and clear it
  function automatic bit close_token(output logic [7:0] ch);
    int n;
    bit found;
    ch = 8'h00;
    found = 1'b0;
    if (tok_len == 0 && !tok_ovf) return 1'b0;
    n = (tbl_count == 0) ? 1 : tbl_count;
    if (token_hits(0)) begin
      ch = tbl_letter[0];
      found = 1'b1;
    end else if (tok[0] == SLASH_BYTE) begin
      ch = SPACE_BYTE;
      found = 1'b1;
    end else begin
      for (int e = 1; e < n && !found; e++) begin
        if (token_hits(e)) begin
          ch = tbl_letter[e];
          found = 1'b1;
        end
      end
    end
    tok_len = 0;
    tok_ovf = 1'b0;
    return found;
  endfunction

  // Advance the model by one accepted byte; returns 1 when a character is owed
  function automatic bit decode_byte(input logic k, input logic [7:0] b, input logic fin,
                                     output logic [7:0] ch);
    int slot;
    ch = 8'h00;
    if (k == KIND_TABLE) begin
      if (b == NEWLINE_BYTE) begin
        line_pos = LP_LETTER;
        line_drop = 1'b0;
        return 1'b0;
      end
      case (line_pos)
        LP_LETTER: begin
          if (tbl_count < MAX_ENTRIES) begin
            tbl_letter[tbl_count] = b;
            tbl_len[tbl_count] = 0;
            tbl_count++;
            line_drop = 1'b0;
          end else begin
            line_drop = 1'b1;
          end
          line_pos = LP_SKIP;
        end
        LP_SKIP: line_pos = LP_CODE;
        default: begin
          if (!line_drop && tbl_count > 0) begin
            slot = tbl_count - 1;
            if (tbl_len[slot] < MAX_CODE_LEN) begin
              tbl_code[slot][tbl_len[slot]] = b;
              tbl_len[slot]++;
            end
          end
        end
      endcase
      if (fin) begin
        line_pos = LP_LETTER;
        line_drop = 1'b0;
      end
      return 1'b0;
    end
    if (is_blank(b)) return close_token(ch);
    if (tok_len < MAX_TOKEN_LEN) begin
      tok[tok_len] = b;
      tok_len++;
    end else begin
      tok_ovf = 1'b1;
    end
    if (fin) return close_token(ch);
    return 1'b0;
  endfunction

  task automatic flag_error(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    $display("%0t: %s: got %02h, expected %02h", $time, what, got, want);
  endtask

  // Stimulus helpers
  function automatic logic [7:0] solid_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NEWLINE_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] code_byte();
    if ($urandom_range(0, 4) == 0) return solid_byte();
    return $urandom_range(0, 1) ? DOT_BYTE : DASH_BYTE;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0: return SPACE_BYTE;
      1: return TAB_BYTE;
      2: return NEWLINE_BYTE;
      3: return VT_BYTE;
      4: return FF_BYTE;
      default: return CR_BYTE;
    endcase
  endfunction

  task automatic put(input logic k, input logic [7:0] b, input logic fin);
    byte_item_t it;
    it.drain = drain_next;
    it.kind = k;
    it.data = b;
    it.fin = fin;
    pending.push_back(it);
    drain_next = 1'b0;
    queued++;
  endtask

  // Send tok_buf[0..n-1], closed by last or by a blank
  task automatic send_token(input int n);
    bit by_last;
    by_last = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) put(KIND_MESSAGE, tok_buf[i], by_last && i == n - 1);
    if (!by_last) put(KIND_MESSAGE, blank_byte(), $urandom_range(0, 3) == 0);
  endtask

  // One table line: letter, skipped byte, code, then newline or last; or letter and newline
  task automatic table_line();
    int n, r, slot;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 8) n = 0;
    else if (r < 88) n = $urandom_range(1, 5);
    else n = $urandom_range(MAX_CODE_LEN + 1, MAX_CODE_LEN + 3);
    slot = pool_n;
    if (pool_n < MAX_ENTRIES) begin
      pool_len[slot] = (n < MAX_CODE_LEN) ? n : MAX_CODE_LEN;
      pool_n++;
    end
    lines_made++;
    put(KIND_TABLE, line_byte(), 1'b0);
    if (n == 0 && $urandom_range(0, 1)) begin
      // newline right after the letter: entry with no code
      put(KIND_TABLE, NEWLINE_BYTE, 1'($urandom_range(0, 1)));
      return;
    end
    put(KIND_TABLE, line_byte(), 1'b0);
    if (n > 0 && $urandom_range(0, 2) == 0) begin
      for (int i = 0; i < n; i++) begin
        c = code_byte();
        if (slot < MAX_ENTRIES && i < MAX_CODE_LEN) pool_code[slot][i] = c;
        put(KIND_TABLE, c, i == n - 1);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        c = code_byte();
        if (slot < MAX_ENTRIES && i < MAX_CODE_LEN) pool_code[slot][i] = c;
        put(KIND_TABLE, c, 1'b0);
      end
      put(KIND_TABLE, NEWLINE_BYTE, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_segment();
    int r, n, idx;
    r = $urandom_range(0, 99);
    if (r < ((lines_made < FULL_LINES) ? 60 : 15)) begin
      table_line();
      return;
    end
    r = $urandom_range(0, 99);
    idx = (pool_n > 0) ? $urandom_range(0, pool_n - 1) : 0;
    if (r < 50 && pool_n > 0 && pool_len[idx] > 0) begin
      // token copied from a known code, sometimes with one byte changed
      n = pool_len[idx];
      for (int i = 0; i < n; i++) tok_buf[i] = pool_code[idx][i];
      if ($urandom_range(0, 4) == 0) tok_buf[$urandom_range(0, n - 1)] = code_byte();
      send_token(n);
    end else if (r < 62) begin
      // word separator, plain or with trailing bytes
      n = $urandom_range(1, 3);
      tok_buf[0] = SLASH_BYTE;
      for (int i = 1; i < n; i++) tok_buf[i] = code_byte();
      send_token(n);
    end else if (r < 72) begin
      // token longer than the buffer
      n = $urandom_range(MAX_TOKEN_LEN + 1, MAX_TOKEN_LEN + 6);
      for (int i = 0; i < n; i++) tok_buf[i] = code_byte();
      if ($urandom_range(0, 1)) tok_buf[0] = SLASH_BYTE;
      send_token(n);
    end else if (r < 88) begin
      n = $urandom_range(0, 3) == 0 ? MAX_TOKEN_LEN : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) tok_buf[i] = $urandom_range(0, 1) ? code_byte() : solid_byte();
      send_token(n);
    end else begin
      // noise: anything on either kind
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        put(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Fill one random phase, set its handshake rates and wait until it is sent
  task automatic run_phase(input int tx, input int rx, input bit pause, input bit hold);
    int start;
    start = queued;
    drain_next = pause;
    while (queued - start < PHASE_ITEMS) random_segment();
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    if (hold) hold_asked++;
    while (pending.size() > 0) @(negedge clk);
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || !byte_stall) begin
      if (pending.size() > 0 && !(pending[0].drain && (byte_valid || chars_due.size() > 0))
          && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = pending.pop_front();
        byte_valid <= 1'b1;
        kind       <= nxt.kind;
        byte_in    <= nxt.data;
        last       <= nxt.fin;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Output stall: random rate, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
    end else if (hold_left > 0) begin
      char_stall <= 1'b1;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen  <= hold_asked;
      hold_left  <= LONG_HOLD;
      char_stall <= 1'b1;
    end else begin
      char_stall <= $urandom_range(0, 99) < rx_stall_pct;
    end
  end

  // Monitor: predict on accepted bytes, check accepted characters
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        if (decode_byte(kind, byte_in, last, ch_new)) chars_due.push_back(ch_new);
      end
      if (char_valid && !char_stall) begin
        if (chars_due.size() == 0) begin
          flag_error("char with none owed", decoded_char, 8'h00);
        end else begin
          ch_want = chars_due.pop_front();
          if (decoded_char !== ch_want) flag_error("decoded_char", decoded_char, ch_want);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int e = 0; e < MAX_ENTRIES; e++) begin
      tbl_letter[e] = 8'h00;
      tbl_len[e] = 0;
      pool_len[e] = 0;
      for (int i = 0; i < MAX_CODE_LEN; i++) tbl_code[e][i] = 8'h00;
    end
    for (int i = 0; i < MAX_TOKEN_LEN; i++) tok[i] = 8'h00;
    tbl_count = 0;
    line_pos = LP_LETTER;
    line_drop = 1'b0;
    tok_len = 0;
    tok_ovf = 1'b0;

    // empty table: a plain token finds nothing, a slash token gives a space
    put(KIND_MESSAGE, DOT_BYTE, 1'b1);
    put(KIND_MESSAGE, SLASH_BYTE, 1'b0);
    put(KIND_MESSAGE, SPACE_BYTE, 1'b0);
    put(KIND_MESSAGE, 8'hFF, 1'b0);
    put(KIND_MESSAGE, TAB_BYTE, 1'b0);
    put(KIND_MESSAGE, 8'h00, 1'b1);
    // first line becomes entry 0: E = "."
    put(KIND_TABLE, "E", 1'b0);
    put(KIND_TABLE, SPACE_BYTE, 1'b0);
    put(KIND_TABLE, DOT_BYTE, 1'b0);
    put(KIND_TABLE, NEWLINE_BYTE, 1'b0);
    put(KIND_MESSAGE, DOT_BYTE, 1'b0);
    put(KIND_MESSAGE, CR_BYTE, 1'b0);
    // newline as first byte of a line: no entry
    put(KIND_TABLE, NEWLINE_BYTE, 1'b1);
    // newline as second byte: entry with an empty code
    put(KIND_TABLE, "T", 1'b0);
    put(KIND_TABLE, NEWLINE_BYTE, 1'b0);
    // last on a code byte closes the line
    put(KIND_TABLE, 8'hFF, 1'b0);
    put(KIND_TABLE, "x", 1'b0);
    put(KIND_TABLE, DASH_BYTE, 1'b1);
    put(KIND_MESSAGE, DASH_BYTE, 1'b1);
    // slash token once entry 0 exists and misses
    put(KIND_MESSAGE, SLASH_BYTE, 1'b0);
    put(KIND_MESSAGE, FF_BYTE, 1'b0);
    // blank with no token pending
    put(KIND_MESSAGE, VT_BYTE, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending.size() > 0) @(negedge clk);

    run_phase(0, 0, 1'b0, 1'b1);
    run_phase(64, 0, 1'b1, 1'b0);
    run_phase(0, 64, 1'b1, 1'b0);
    run_phase(30, 30, 1'b0, 1'b0);
    run_phase(0, 0, 1'b1, 1'b0);

    while (byte_valid) @(negedge clk);
    while (chars_due.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && chars_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
